>>> rtl/stfl_pkg.sv
// stfl_pkg: shared widths, types and helpers of the sorted table search block.
// Stands alone; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package stfl_pkg;

	localparam int TableDepth = 256;
	localparam int AddrW      = $clog2(TableDepth);
	localparam int LenW       = AddrW + 1;
	localparam int PtrW       = AddrW + 2;
	localparam int ValueW     = 32;
	localparam int IdxW       = 9;
	localparam int CountW     = 9;

	typedef logic signed [ValueW-1:0] value_t;
	typedef logic signed [PtrW-1:0]   ptr_t;
	typedef logic        [AddrW-1:0]  addr_t;
	typedef logic        [LenW-1:0]   len_t;
	typedef logic        [7:0]        entry_idx_t;
	typedef logic signed [IdxW-1:0]   out_idx_t;
	typedef logic        [CountW-1:0] count_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// Search window of one binary search pass.
	typedef struct packed {
		ptr_t  lo;
		ptr_t  hi;
		ptr_t  found;
		logic  live;
		addr_t mid;
	} probe_t;

	localparam ptr_t NotFound = '1;

	// Window for a fresh pass over the first len entries, clamped to the depth.
	function automatic probe_t probe_init(input len_t len);
		len_t                n;
		logic [PtrW-1:0]     sum;
		probe_t              p;
		n       = (len > len_t'(TableDepth)) ? len_t'(TableDepth) : len;
		p.lo    = '0;
		p.hi    = ptr_t'(n) - ptr_t'(1);
		p.found = NotFound;
		p.live  = (p.lo <= p.hi);
		sum     = p.lo + p.hi;
		p.mid   = sum[AddrW:1];
		return p;
	endfunction

endpackage

>>> rtl/stfl_if.sv
// stfl_if: valid/ready channel interfaces of the sorted table search block.
// Depends on stfl_pkg for field types.
`timescale 1ns / 1ps

interface stfl_req_if;
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	stfl_pkg::entry_idx_t   entry_index;
	stfl_pkg::value_t       entry_value;
	stfl_pkg::value_t       search_key;

	modport source (output valid, opcode, entry_index, entry_value, search_key, input ready);
	modport sink   (input valid, opcode, entry_index, entry_value, search_key, output ready);
endinterface

interface stfl_rsp_if;
	logic                   valid;
	logic                   ready;
	stfl_pkg::out_idx_t     first_index;
	stfl_pkg::out_idx_t     last_index;
	stfl_pkg::count_t       occurrence_count;

	modport source (output valid, first_index, last_index, occurrence_count, input ready);
	modport sink   (input valid, first_index, last_index, occurrence_count, output ready);
endinterface

interface stfl_cfg_if;
	logic                   valid;
	logic                   ready;
	stfl_pkg::len_t         data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> rtl/stfl_step.sv
// stfl_step: the shared compare unit; one binary search probe per use.
// Depends on stfl_pkg for the window type.
`timescale 1ns / 1ps

module stfl_step (
	input  stfl_pkg::probe_t cur,
	input  stfl_pkg::value_t value,
	input  stfl_pkg::value_t key,
	input  logic             want_last,
	output stfl_pkg::probe_t nxt
);

	stfl_pkg::ptr_t                mid_ext;
	logic [stfl_pkg::PtrW-1:0]     sum;

	always_comb begin
		mid_ext = stfl_pkg::ptr_t'({2'b00, cur.mid});
		nxt     = cur;
		if (value == key) begin
			nxt.found = mid_ext;
			if (want_last) begin
				nxt.lo = mid_ext + stfl_pkg::ptr_t'(1);
			end else begin
				nxt.hi = mid_ext - stfl_pkg::ptr_t'(1);
			end
		end else if (value < key) begin
			nxt.lo = mid_ext + stfl_pkg::ptr_t'(1);
		end else begin
			nxt.hi = mid_ext - stfl_pkg::ptr_t'(1);
		end
		nxt.live = (nxt.lo <= nxt.hi);
		sum      = nxt.lo + nxt.hi;
		nxt.mid  = sum[stfl_pkg::AddrW:1];
	end

endmodule

>>> rtl/stfl_core.sv
// stfl_core: table memory, search sequencer and result register.
// Depends on stfl_pkg, the channel interfaces and stfl_step.
`timescale 1ns / 1ps

module stfl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  stfl_pkg::len_t    len,
	stfl_req_if.sink          req,
	stfl_rsp_if.source        rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PASS,
		S_PROBE,
		S_FINISH
	} state_t;

	state_t             state_q;
	stfl_pkg::probe_t   pr_q;
	stfl_pkg::probe_t   step_nxt;
	stfl_pkg::probe_t   init_pr;
	stfl_pkg::probe_t   cur_pr;
	logic               want_last_q;
	stfl_pkg::value_t   key_q;
	stfl_pkg::ptr_t     first_q;
	stfl_pkg::ptr_t     last_q;
	stfl_pkg::ptr_t     span;
	logic               rsp_valid_q;
	stfl_pkg::out_idx_t first_out_q;
	stfl_pkg::out_idx_t last_out_q;
	stfl_pkg::count_t   count_out_q;

	stfl_pkg::value_t   mem [stfl_pkg::TableDepth];
	stfl_pkg::value_t   rdata_s1;
	logic               mem_we;
	logic               mem_re;
	stfl_pkg::addr_t    mem_raddr;

	logic               accept;
	logic               pass_end;

	stfl_step u_step (
		.cur       (pr_q),
		.value     (rdata_s1),
		.key       (key_q),
		.want_last (want_last_q),
		.nxt       (step_nxt)
	);

	assign init_pr   = stfl_pkg::probe_init(len);
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign mem_we    = accept && (stfl_pkg::opcode_t'(req.opcode) == stfl_pkg::OP_LOAD);

	// Window that the current cycle decides on.
	always_comb begin
		cur_pr = (state_q == S_PROBE) ? step_nxt : pr_q;
	end

	assign pass_end  = ((state_q == S_PASS) || (state_q == S_PROBE)) && !cur_pr.live;
	assign mem_re    = ((state_q == S_PASS) || (state_q == S_PROBE)) && cur_pr.live;
	assign mem_raddr = cur_pr.mid;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[req.entry_index[stfl_pkg::AddrW-1:0]] <= req.entry_value;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	assign span = last_q - first_q + stfl_pkg::ptr_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			want_last_q <= 1'b0;
			key_q       <= '0;
			pr_q        <= '0;
			first_q     <= '0;
			last_q      <= '0;
			first_out_q <= '0;
			last_out_q  <= '0;
			count_out_q <= '0;
		end else begin
			// Drop the result once taken; the finish state reloads it itself.
			if (rsp_valid_q && rsp.ready && state_q != S_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && stfl_pkg::opcode_t'(req.opcode) == stfl_pkg::OP_QUERY) begin
						key_q       <= req.search_key;
						pr_q        <= init_pr;
						want_last_q <= 1'b0;
						state_q     <= S_PASS;
					end
				end
				S_PASS, S_PROBE: begin
					pr_q <= cur_pr;
					if (mem_re) begin
						state_q <= S_PROBE;
					end else if (pass_end && !want_last_q) begin
						// First pass done: hold its answer, rerun for the rightmost.
						first_q     <= cur_pr.found;
						pr_q        <= init_pr;
						want_last_q <= 1'b1;
						state_q     <= S_PASS;
					end else begin
						last_q  <= cur_pr.found;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						first_out_q <= first_q[stfl_pkg::IdxW-1:0];
						last_out_q  <= last_q[stfl_pkg::IdxW-1:0];
						if (first_q >= 0 && last_q >= first_q) begin
							count_out_q <= span[stfl_pkg::CountW-1:0];
						end else begin
							count_out_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.first_index      = first_out_q;
	assign rsp.last_index       = last_out_q;
	assign rsp.occurrence_count = count_out_q;

endmodule

>>> rtl/sorted_table_first_last_search.sv
// Sorted table first/last search, top level; depends on stfl_pkg, the channel
// interfaces and stfl_core. The block keeps a 256-entry table of signed 32-bit
// values, meant to be in ascending order. A load item (opcode 0) writes one
// entry and gives no result. A query item (opcode 1) runs two
// binary searches over the first table_length entries (clamped to 256): one for
// the leftmost and one for the rightmost entry equal to the key, and returns
// both indices (-1 when absent) and the occurrence count. Each probe is one
// registered read of the table port followed by one compare in the shared
// compare unit; the next read address is issued in the same cycle as the
// compare. A query runs its two passes one after the other, with at most 9
// probes per pass. The request channel is not ready while a query runs. A
// finished result sits in an output register, so new items are taken while
// it waits. table_length is written through the cfg channel; the user must
// write it only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps

module sorted_table_first_last_search (
	input  logic         clk,
	input  logic         arst_n,
	stfl_req_if.sink     req,
	stfl_rsp_if.source   rsp,
	stfl_cfg_if.sink     cfg
);

	stfl_pkg::len_t len_q;

	// Take register writes at any time; the user must change the length only while idle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			len_q <= cfg.data;
		end
	end

	// Hold the table and run both searches under one sequencer.
	stfl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.len    (len_q),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> dv/sorted_table_first_last_search_tb.sv
// Testbench for sorted_table_first_last_search: loads table entries, sets the length
// register and checks every query result against an in-bench first/last search.
// Depends on rtl/stfl_pkg.sv, rtl/stfl_if.sv and the block's top level.
`timescale 1ns / 1ps

module sorted_table_first_last_search_tb;
	import stfl_pkg::*;

	localparam int HalfPeriod   = 5;
	localparam int ResetCycles  = 11;
	// Give the block room to finish a query before idle work.
	localparam int SettleCycles = 40;
	// Long receiver hold-off used to back the block up into its request port.
	localparam int HoldCycles   = 400;
	// Cycles with no handshake on any channel before the run is declared hung.
	localparam int StallLimit   = 3000;

	localparam value_t MinValue = 32'sh8000_0000;
	localparam value_t MaxValue = 32'sh7fff_ffff;

	// Directed table: duplicates at both ends and in the middle, both extremes present.
	localparam value_t Ladder [8] = '{
		32'sh8000_0000, 32'sh8000_0000, -32'sd1, 32'sd0,
		32'sd0, 32'sd0, 32'sh7fff_ffff, 32'sh7fff_ffff
	};

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idling_t;

	typedef struct {
		out_idx_t first;
		out_idx_t last;
		count_t   count;
	} span_t;

	// Mirrors the table and the length register, predicts the span of each query
	// and checks the block's results in order.
	class search_checker;
		value_t entries [TableDepth];
		len_t   length;
		span_t  awaited [$];
		int     mismatches;

		function new();
			foreach (entries[i]) entries[i] = '0;
			length     = '0;
			mismatches = 0;
		endfunction

		function void set_length(len_t len);
			length = len;
		endfunction

		// Binary search over the active window; want_last walks to the right edge.
		function int find_edge(value_t key, bit want_last);
			int lo;
			int hi;
			int mid;
			int found;
			lo    = 0;
			hi    = ((length > len_t'(TableDepth)) ? TableDepth : int'(length)) - 1;
			found = -1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (entries[mid] == key) begin
					found = mid;
					if (want_last)
						lo = mid + 1;
					else
						hi = mid - 1;
				end else if (entries[mid] < key) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			return found;
		endfunction

		function void note_item(opcode_t op, entry_idx_t idx, value_t val, value_t key);
			span_t s;
			int    first;
			int    last;
			if (op == OP_LOAD) begin
				entries[idx] = val;
			end else begin
				first   = find_edge(key, 1'b0);
				last    = find_edge(key, 1'b1);
				s.first = out_idx_t'(first);
				s.last  = out_idx_t'(last);
				s.count = (first >= 0 && last >= first) ? count_t'(last - first + 1) : '0;
				awaited.push_back(s);
			end
		endfunction

		function void check_result(out_idx_t first, out_idx_t last, count_t count);
			span_t s;
			if (awaited.size() == 0) begin
				$error("result with no query outstanding: first_index %0d, last_index %0d, occurrence_count %0d",
					first, last, count);
				mismatches++;
			end else begin
				s = awaited.pop_front();
				if (first !== s.first) begin
					$error("first_index: expected %0d, actual %0d", s.first, first);
					mismatches++;
				end
				if (last !== s.last) begin
					$error("last_index: expected %0d, actual %0d", s.last, last);
					mismatches++;
				end
				if (count !== s.count) begin
					$error("occurrence_count: expected %0d, actual %0d", s.count, count);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stfl_req_if req_ch ();
	stfl_rsp_if rsp_ch ();
	stfl_cfg_if cfg_ch ();

	search_checker board;

	int     src_idle_pct;
	int     snk_stall_pct;
	bit     hold_request;
	int     idle_cycles;
	// Stimulus-side copy of what has been sent to the table, used to aim query keys.
	value_t staged [TableDepth];

	sorted_table_first_last_search DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always #HalfPeriod clk = ~clk;

	// Sample all three channels at the rising edge. Inputs only move at the falling
	// edge, so the values seen here are the ones the block sees. Results are checked
	// before a new query is noted; the two cannot coincide for the same query anyway.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			board.check_result(rsp_ch.first_index, rsp_ch.last_index, rsp_ch.occurrence_count);
		if (req_ch.valid && req_ch.ready)
			board.note_item(opcode_t'(req_ch.opcode), req_ch.entry_index, req_ch.entry_value,
				req_ch.search_key);
		if (cfg_ch.valid && cfg_ch.ready)
			board.set_length(cfg_ch.data);

		// Watchdog: count edges with no handshake anywhere.
		if (!arst_n || (rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("sorted_table_first_last_search_tb: errors");
			$finish;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
	end

	// Result side: stall at random, or hold off for a long counted stretch when the
	// stimulus asks for it. One update of ready per falling edge outside a hold-off.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				rsp_ch.ready <= !(snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct);
			end
		end
	end

	function automatic void set_idling(idling_t mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct  = 0;
				snk_stall_pct = 0;
			end
			IDLE_SENDER: begin
				src_idle_pct  = 55;
				snk_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				src_idle_pct  = 0;
				snk_stall_pct = 55;
			end
			default: begin
				src_idle_pct  = 22;
				snk_stall_pct = 22;
			end
		endcase
	endfunction

	// Offer one item and return at the edge that takes it. Valid stays high into the
	// next call, which decides at its own falling edge whether to idle.
	task automatic send_item(opcode_t op, entry_idx_t idx, value_t val, value_t key);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.entry_index <= idx;
		req_ch.entry_value <= val;
		req_ch.search_key  <= key;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Unused payload fields carry noise so that the block must ignore them.
	task automatic load_entry(entry_idx_t idx, value_t val);
		staged[idx] = val;
		send_item(OP_LOAD, idx, val, value_t'($urandom));
	endtask

	task automatic search_for(value_t key);
		send_item(OP_QUERY, entry_idx_t'($urandom), value_t'($urandom), key);
	endtask

	// Drop valid, wait for every outstanding result, then let the block go quiet.
	task automatic quiesce();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_length(len_t len);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= len;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly keys that are in the table; otherwise neighbors, extremes or noise.
	function automatic value_t pick_key(int n);
		int     r;
		value_t v;
		if (n == 0)
			return value_t'($urandom);
		r = $urandom_range(99);
		v = staged[$urandom_range(n - 1)];
		if (r < 60)
			return v;
		else if (r < 80)
			return $urandom_range(1) ? v + 1 : v - 1;
		else if (r < 90)
			return $urandom_range(1) ? MaxValue : MinValue;
		else
			return value_t'($urandom);
	endfunction

	// Load entries 0..n-1 in ascending order; about a third of the steps repeat the
	// previous value, and the ramp saturates at the top so duplicates gather there.
	task automatic fill_sorted(int n, int step_max);
		longint cur;
		int     i;
		if ($urandom_range(3) == 0)
			cur = longint'(MinValue);
		else
			cur = longint'(value_t'($urandom)) / 2;
		for (i = 0; i < n; i++) begin
			load_entry(entry_idx_t'(i), value_t'(cur));
			if ($urandom_range(2) != 0)
				cur = cur + longint'($urandom_range(step_max, 1));
			if (cur > longint'(MaxValue))
				cur = longint'(MaxValue);
		end
	endtask

	// One random phase: set the length while idle, (re)load the searched prefix,
	// optionally break its order, add ignored-region loads, then fire queries.
	task automatic run_phase(int len, int n_queries, idling_t mode, int step_max,
			bit reload, bit scramble, bit squeeze, bit pause_midway);
		int n;
		int i;
		n = (len > TableDepth) ? TableDepth : len;
		quiesce();
		set_idling(mode);
		write_length(len_t'(len));
		if (reload)
			fill_sorted(n, step_max);
		if (scramble && n > 0)
			repeat (3) load_entry(entry_idx_t'($urandom_range(n - 1)), value_t'($urandom));
		if (n < TableDepth)
			repeat (3) load_entry(entry_idx_t'($urandom_range(TableDepth - 1, n)),
				value_t'($urandom));
		// Back-pressure: hold results while queries keep coming, so the input stalls.
		if (squeeze)
			hold_request = 1'b1;
		for (i = 0; i < n_queries; i++) begin
			// Pause the sender until every result is back, then resume.
			if (pause_midway && i == n_queries / 2)
				quiesce();
			search_for(pick_key(n));
		end
	endtask

	initial begin
		int p;
		int len;
		int i;
		board = new();

		// Drive every input to a known value from time zero.
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_LOAD;
		req_ch.entry_index = '0;
		req_ch.entry_value = '0;
		req_ch.search_key  = '0;
		rsp_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		hold_request       = 1'b0;
		idle_cycles        = 0;
		set_idling(IDLE_NONE);

		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table: nothing is searched, every key misses.
		write_length('0);
		search_for(32'sd0);
		search_for(MinValue);

		// Small sorted table with runs at both ends and in the middle.
		for (i = 0; i < 8; i++)
			load_entry(entry_idx_t'(i), Ladder[i]);
		quiesce();
		write_length(len_t'(8));
		search_for(MinValue);
		search_for(MaxValue);
		search_for(32'sd0);
		search_for(-32'sd1);
		search_for(32'sd1);
		search_for(-32'sd5);

		// Break the order: the searches must still follow the same probe path.
		load_entry(entry_idx_t'(2), MaxValue);
		search_for(MaxValue);
		search_for(-32'sd1);

		// Single-entry window.
		quiesce();
		write_length(len_t'(1));
		search_for(MinValue);
		search_for(32'sd0);

		// Full table with heavy duplication, with a long result hold-off.
		run_phase(TableDepth, 40, IDLE_NONE, 4, 1'b1, 1'b0, 1'b1, 1'b0);
		// Length above the depth clamps to the full table; reuse what is loaded.
		run_phase(511, 30, IDLE_SENDER, 1, 1'b0, 1'b0, 1'b0, 1'b0);

		// Short tables under every idling pattern; every fourth one is unsorted.
		for (p = 0; p < 10; p++) begin
			if (p == 0)
				len = 1;
			else if (p == 1)
				len = 2;
			else
				len = $urandom_range(32, 3);
			run_phase(len, 20, idling_t'(p % 4),
				(p % 3 == 0) ? 1 : ((p % 3 == 1) ? 1000 : 32'h2000_0000),
				1'b1, (p % 4 == 3), 1'b0, (p == 2 || p == 6));
		end

		quiesce();
		if (board.mismatches == 0 && board.pending() == 0)
			$display("sorted_table_first_last_search_tb: clean");
		else
			$display("sorted_table_first_last_search_tb: errors");
		$finish;
	end

endmodule
